// ===== rtl/bws_pkg.sv =====
// Shared types and constants for the balancing window search block.
package bws_pkg;

   localparam int WORD_W       = 16;
   localparam int POSITION_W   = 4;
   localparam int WIN_START_W  = 3;
   localparam int WIN_END_W    = 5;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 8;
   localparam int TOL_W        = 3;

   localparam logic [CSR_INDEX_W-1:0] CSR_SEARCH_MODE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TOLERANCE   = 2'd1;

   localparam logic       MODE_RESET = 1'b0;
   localparam logic [2:0] TOL_RESET  = 3'd2;

   typedef enum logic [1:0] {
      RES_OK,
      RES_IN_BAND,
      RES_FAIL
   } result_kind_type;

   typedef struct packed {
      logic            load;
      logic            count;
      logic            prep;
      logic            pass_exact;
      logic            pass_tol;
      logic            step;
      logic            eval;
      logic            emit;
      result_kind_type kind;
   } dp_cmd_type;

   typedef struct packed {
      logic chunk_last;
      logic stride_zero;
      logic stride_le_tol;
      logic diff_zero;
      logic pass_last;
      logic pos_end;
      logic in_band;
      logic out_free;
   } dp_status_type;

endpackage

// ===== rtl/bws_ifs.sv =====
// Channel interfaces: request, response and register write.
interface bws_req_if import bws_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] word;

   modport source (output valid, output word, input ready);
   modport sink   (input valid, input word, output ready);
endinterface

interface bws_rsp_if import bws_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [POSITION_W-1:0]  position;
   logic [WIN_START_W-1:0] window_start;
   logic [WIN_END_W-1:0]   window_end;
   logic                   in_band;
   logic                   no_balance;

   modport source (output valid, output position, output window_start, output window_end,
                   output in_band, output no_balance, input ready);
   modport sink   (input valid, input position, input window_start, input window_end,
                   input in_band, input no_balance, output ready);
endinterface

interface bws_csr_if import bws_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/balancing_window_search.sv =====
// Top level of the balancing window search block with its configuration registers.
//
// A word arrives on req_chan and one result leaves on rsp_chan per word; both
// channels move a transfer when valid and ready are high at a rising clock edge.
// Registers are written on csr_chan (index 0 search mode, 1 tolerance), which is
// always ready; other indexes are ignored. Write them only while the block is idle.
// One word is processed at a time. The popcounts are gathered eight bits per
// cycle, then the search is set up. Each pass is a check, one half-bit step per
// cycle and an evaluation, and at most WORD_BITS steps are taken. An in-band word
// goes straight from the setup to the result, and a word that needs no step gets
// its result after the first check. The controller then returns to idle, where it
// takes the next word.
// The result sits in an output register; the next word is accepted while it waits.
// If the receiver stalls, a finished word waits in the controller until the output
// register is free, and no new word is taken meanwhile.
// Synchronous reset empties the output register, returns the controller to idle,
// and sets search mode to exact and tolerance to two.
module balancing_window_search import bws_pkg::*; #(
   parameter int WORD_BITS = 16
) (
   input logic       clock,
   input logic       reset,
   bws_req_if.sink   req_chan,
   bws_rsp_if.source rsp_chan,
   bws_csr_if.sink   csr_chan
);

   logic             mode_ff;
   logic [TOL_W-1:0] tol_ff;
   dp_cmd_type       cmd;
   dp_status_type    status;
   logic             ctl_ready;

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_RESET;
         tol_ff  <= TOL_RESET;
      end else if (csr_chan.valid) begin
         case (csr_chan.index)
            CSR_SEARCH_MODE: mode_ff <= csr_chan.data[0];
            CSR_TOLERANCE:   tol_ff  <= csr_chan.data[TOL_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign req_chan.ready = ctl_ready;

   bws_controller u_ctl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (ctl_ready),
      .mode      (mode_ff),
      .status    (status),
      .cmd       (cmd)
   );

   bws_datapath #(
      .WORD_BITS (WORD_BITS)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .word     (req_chan.word),
      .mode     (mode_ff),
      .tol      (tol_ff),
      .cmd      (cmd),
      .status   (status),
      .rsp_chan (rsp_chan)
   );

endmodule

// ===== rtl/bws_datapath.sv =====
// Datapath: popcount scan, sliding window sums, pass counter and result register.
module bws_datapath import bws_pkg::*; #(
   parameter int WORD_BITS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [WORD_W-1:0]   word,
   input  logic                mode,
   input  logic [TOL_W-1:0]    tol,
   input  dp_cmd_type          cmd,
   output dp_status_type       status,
   bws_rsp_if.source           rsp_chan
);

   localparam int N      = WORD_BITS;
   localparam int HALF   = N / 2;
   localparam int PW     = $clog2(N + 1);
   localparam int TW     = $clog2(N + 1);
   localparam int SW     = $clog2(N + 2) + 2;
   localparam int CHUNKS = (N + 7) / 8;
   localparam int PADW   = CHUNKS * 8;
   localparam int CW     = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
   localparam int BW     = $clog2(N);
   localparam int LW     = (N > WORD_W) ? N : WORD_W;
   localparam int EW     = PW + 2;
   localparam logic [PADW-1:0] HMASK = PADW'((65'(1) << HALF) - 65'(1));

   logic [N-1:0]           word_ff;
   logic [PADW-1:0]        scan_ff, hm_ff;
   logic [CW-1:0]          chunk_ff;
   logic [TW-1:0]          t_ff;
   logic signed [SW-1:0]   s_ff, stride_ff;
   logic [PW-1:0]          pos_ff;
   logic [SW-1:0]          kcnt_ff;

   logic                   rsp_valid_ff;
   logic [POSITION_W-1:0]  position_ff;
   logic [WIN_START_W-1:0] start_ff;
   logic [WIN_END_W-1:0]   end_ff;
   logic                   in_band_ff, no_balance_ff;

   logic [LW-1:0]          word_ext;
   logic [3:0]             cnt_t, cnt_s;
   logic signed [SW-1:0]   t_sw, diff, abs_diff, tol_sw, mid, test, test_diff, adj;
   logic [BW-1:0]          lo_idx, hi_idx;
   logic [PW:0]            hi_sum;
   logic [EW-1:0]          end_sum;
   logic                   bit_lo, bit_hi;

   assign word_ext = LW'(word);

   always_comb begin
      cnt_t = '0;
      cnt_s = '0;
      for (int i = 0; i < 8; i++) begin
         cnt_t = cnt_t + 4'(scan_ff[i]);
         cnt_s = cnt_s + 4'(scan_ff[i] & hm_ff[i]);
      end
   end

   assign t_sw     = $signed(SW'(t_ff));
   assign diff     = s_ff - t_sw;
   assign abs_diff = (diff < 0) ? -diff : diff;
   assign tol_sw   = $signed(SW'(tol));
   assign mid      = $signed(SW'(HALF));

   assign lo_idx = BW'(pos_ff >> 1);
   assign hi_sum = (PW + 1)'(pos_ff) + (PW + 1)'(N);
   assign hi_idx = BW'(hi_sum >> 1);
   assign bit_lo = word_ff[lo_idx];
   assign bit_hi = word_ff[hi_idx];

   // At odd positions the window straddles half bits, so both edge bits count half.
   assign adj       = $signed(SW'(bit_lo)) + $signed(SW'(bit_hi)) - $signed(SW'(1));
   assign test      = pos_ff[0] ? (s_ff + adj) : s_ff;
   assign test_diff = (test - t_sw < 0) ? (t_sw - test) : (test - t_sw);

   assign end_sum = EW'(pos_ff) + EW'(N + 1);

   always_comb begin
      status.chunk_last    = (chunk_ff == CW'(CHUNKS - 1));
      status.stride_zero   = (stride_ff == '0);
      status.stride_le_tol = (stride_ff <= tol_sw);
      status.diff_zero     = (abs_diff == '0);
      status.pass_last     = (kcnt_ff == SW'(1));
      status.pos_end       = (pos_ff >= PW'(N));
      status.in_band       = mode && (t_sw >= mid - tol_sw) && (t_sw <= mid + tol_sw);
      status.out_free      = !rsp_valid_ff || rsp_chan.ready;
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         word_ff  <= word_ext[N-1:0];
         scan_ff  <= PADW'(word_ext[N-1:0]);
         hm_ff    <= HMASK;
         chunk_ff <= '0;
         t_ff     <= '0;
         s_ff     <= '0;
         pos_ff   <= '0;
      end
      if (cmd.count) begin
         scan_ff  <= scan_ff >> 8;
         hm_ff    <= hm_ff >> 8;
         chunk_ff <= chunk_ff + CW'(1);
         t_ff     <= t_ff + TW'(cnt_t);
         s_ff     <= s_ff + $signed(SW'({cnt_s, 1'b0}));
      end
      if (cmd.prep) begin
         stride_ff <= abs_diff;
      end
      if (cmd.pass_exact) begin
         kcnt_ff <= SW'(abs_diff);
      end
      if (cmd.pass_tol) begin
         kcnt_ff <= SW'({tol, 1'b1});
      end
      if (cmd.step) begin
         s_ff    <= s_ff - $signed(SW'(bit_lo)) + $signed(SW'(bit_hi));
         pos_ff  <= pos_ff + PW'(1);
         kcnt_ff <= kcnt_ff - SW'(1);
      end
      if (cmd.eval) begin
         stride_ff <= test_diff;
      end
      if (cmd.emit) begin
         if (cmd.kind == RES_OK) begin
            position_ff <= POSITION_W'(pos_ff);
            start_ff    <= WIN_START_W'(pos_ff >> 1);
            end_ff      <= WIN_END_W'(end_sum >> 1);
         end else begin
            position_ff <= '0;
            start_ff    <= '0;
            end_ff      <= '0;
         end
         in_band_ff    <= (cmd.kind == RES_IN_BAND);
         no_balance_ff <= (cmd.kind == RES_FAIL);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.position     = position_ff;
   assign rsp_chan.window_start = start_ff;
   assign rsp_chan.window_end   = end_ff;
   assign rsp_chan.in_band      = in_band_ff;
   assign rsp_chan.no_balance   = no_balance_ff;

endmodule

// ===== rtl/bws_controller.sv =====
// Controller: sequences the count, search passes and result hand-off.
module bws_controller import bws_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  logic          mode,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_COUNT,
      ST_PREP,
      ST_CHECK,
      ST_STEP,
      ST_EVAL,
      ST_DONE
   } state_type;

   state_type       state_ff, state_in;
   result_kind_type kind_ff, kind_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in       = state_ff;
      kind_in        = kind_ff;
      cmd            = '0;
      cmd.kind       = kind_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_COUNT;
            end
         end
         ST_COUNT: begin
            cmd.count = 1'b1;
            if (status.chunk_last) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            if (status.in_band) begin
               kind_in  = RES_IN_BAND;
               state_in = ST_DONE;
            end else begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (!mode) begin
               if (status.stride_zero) begin
                  kind_in  = RES_OK;
                  state_in = ST_DONE;
               end else if (status.diff_zero) begin
                  // A pass of zero steps would never move: the search has stalled.
                  kind_in  = RES_FAIL;
                  state_in = ST_DONE;
               end else begin
                  cmd.pass_exact = 1'b1;
                  state_in       = ST_STEP;
               end
            end else begin
               if (status.stride_le_tol) begin
                  kind_in  = RES_OK;
                  state_in = ST_DONE;
               end else begin
                  cmd.pass_tol = 1'b1;
                  state_in     = ST_STEP;
               end
            end
         end
         ST_STEP: begin
            if (status.pos_end) begin
               kind_in  = RES_FAIL;
               state_in = ST_DONE;
            end else begin
               cmd.step = 1'b1;
               if (status.pass_last) begin
                  state_in = ST_EVAL;
               end
            end
         end
         ST_EVAL: begin
            if (status.pos_end) begin
               kind_in  = RES_FAIL;
               state_in = ST_DONE;
            end else begin
               cmd.eval = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_DONE: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         kind_ff  <= RES_OK;
      end else begin
         state_ff <= state_in;
         kind_ff  <= kind_in;
      end
   end

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the balancing window search block.
module tb_top;
   import bws_pkg::*;

   localparam int HOLD_LEN     = 300;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int PHASE_WORDS  = 100;
   localparam int SETTLE_WAIT  = 20;
   // No register lives at this index, so a write here must change nothing.
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;

   typedef struct packed {
      logic [POSITION_W-1:0]  position;
      logic [WIN_START_W-1:0] window_start;
      logic [WIN_END_W-1:0]   window_end;
      logic                   in_band;
      logic                   no_balance;
   } window_result_type;

   logic clock = 1'b0;
   logic reset;

   bws_req_if req_chan ();
   bws_rsp_if rsp_chan ();
   bws_csr_if csr_chan ();

   balancing_window_search #(.WORD_BITS(WORD_W)) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   always #1 clock = ~clock;

   logic                 cur_mode = MODE_RESET;
   logic [TOL_W-1:0]     cur_tol  = TOL_RESET;
   logic                 steady   = 1'b0;
   logic                 holding  = 1'b0;
   int                   hold_cycles = 0;
   int                   cycle_count = 0;
   int                   mismatch_count = 0;
   logic [WORD_W-1:0]    pending_words[$];
   window_result_type    expected_windows[$];

   function automatic int iabs(int v);
      return (v < 0) ? -v : v;
   endfunction

   function automatic int word_bit(logic [WORD_W-1:0] w, int i);
      return (i < WORD_W) ? int'(w[i]) : 0;
   endfunction

   // Expected outcome of the window search for one word under the given settings.
   function automatic window_result_type search_window(logic [WORD_W-1:0] w, logic mode,
                                                       logic [TOL_W-1:0] tol_reg);
      int n, half, tol, t, s, stride, pos, kend, k, test;
      bit inband, fail, done;
      window_result_type r;
      n      = WORD_W;
      half   = n / 2;
      tol    = int'(tol_reg);
      t      = $countones(w);
      s      = 2 * $countones(w[WORD_W/2-1:0]);
      stride = iabs(s - t);
      pos    = 0;
      kend   = 0;
      inband = 1'b0;
      fail   = 1'b0;
      done   = 1'b0;
      if (mode)
         inband = (t >= half - tol) && (t <= half + tol);
      if (!inband) begin
         while (!done) begin
            if (!mode) begin
               if (stride == 0) begin
                  done = 1'b1;
               end else begin
                  kend = iabs(s - t);
                  // A pass of no steps while the test value still misses means a stall.
                  if (kend == 0) begin
                     fail = 1'b1;
                     done = 1'b1;
                  end
               end
            end else begin
               if (stride <= tol)
                  done = 1'b1;
               else
                  kend = 2 * tol + 1;
            end
            if (!done) begin
               for (k = 0; k < kend && !fail; k++) begin
                  if (pos >= n) begin
                     fail = 1'b1;
                  end else begin
                     s = s - word_bit(w, pos >> 1) + word_bit(w, (pos + n) >> 1);
                     pos++;
                  end
               end
               if (!fail && pos >= n)
                  fail = 1'b1;
               if (fail) begin
                  done = 1'b1;
               end else begin
                  test = s;
                  if (pos % 2 == 1)
                     test = test + word_bit(w, pos >> 1) + word_bit(w, (pos + n) >> 1) - 1;
                  stride = iabs(test - t);
               end
            end
         end
      end
      r = '0;
      if (!inband && !fail) begin
         r.position     = POSITION_W'(pos);
         r.window_start = WIN_START_W'(pos >> 1);
         r.window_end   = WIN_END_W'((pos + n + 1) >> 1);
      end
      r.in_band    = inband;
      r.no_balance = fail;
      return r;
   endfunction

   task automatic check_field(string field, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
         mismatch_count++;
      end
   endtask

   // Word driver: offers the next pending word, predicting its result on each transfer.
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready)
            expected_windows.push_back(search_window(req_chan.word, cur_mode, cur_tol));
         if (!req_chan.valid || req_chan.ready) begin
            if (pending_words.size() != 0 && (steady || $urandom_range(0, 99) >= 38)) begin
               req_chan.valid <= 1'b1;
               req_chan.word  <= pending_words.pop_front();
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // Result receiver: random stalls, plus one long hold-off that fills the block up.
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else if (holding && hold_cycles < HOLD_LEN) begin
         rsp_chan.ready <= 1'b0;
         hold_cycles    <= hold_cycles + 1;
      end else begin
         rsp_chan.ready <= steady || ($urandom_range(0, 99) >= 38);
      end
   end

   // Result monitor.
   always @(posedge clock) begin
      window_result_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_windows.size() == 0) begin
            $display("%0t: result transfer with no word outstanding", $time);
            mismatch_count++;
         end else begin
            want = expected_windows.pop_front();
            check_field("position", 8'(want.position), 8'(rsp_chan.position));
            check_field("window_start", 8'(want.window_start), 8'(rsp_chan.window_start));
            check_field("window_end", 8'(want.window_end), 8'(rsp_chan.window_end));
            check_field("in_band", 8'(want.in_band), 8'(rsp_chan.in_band));
            check_field("no_balance", 8'(want.no_balance), 8'(rsp_chan.no_balance));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb_top NOT OK");
         $finish;
      end
   end

   task automatic write_reg(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= index;
      csr_chan.data  <= data;
      do @(posedge clock); while (!csr_chan.ready);
      if (index == CSR_SEARCH_MODE)
         cur_mode = data[0];
      else if (index == CSR_TOLERANCE)
         cur_tol = data[TOL_W-1:0];
   endtask

   // Upper data bits are random; the block must ignore them.
   task automatic configure(logic mode, logic [TOL_W-1:0] tol);
      write_reg(CSR_SEARCH_MODE, (CSR_DATA_W'($urandom) << 1) | CSR_DATA_W'(mode));
      write_reg(CSR_TOLERANCE, (CSR_DATA_W'($urandom) << TOL_W) | CSR_DATA_W'(tol));
      csr_chan.valid <= 1'b0;
   endtask

   task automatic wait_idle();
      while (pending_words.size() != 0 || req_chan.valid || expected_windows.size() != 0)
         @(posedge clock);
   endtask

   initial begin
      logic [WORD_W-1:0] directed_words[12];
      int                phase_mode[8];
      int                phase_tol[8];
      logic [WORD_W-1:0] a, b, c, w;
      directed_words = '{16'h0000, 16'hFFFF, 16'h00FF, 16'hFF00, 16'h5555, 16'hAAAA,
                         16'h0001, 16'h8000, 16'h0F0F, 16'h000F, 16'h7FFF, 16'h0100};
      phase_mode = '{0, 1, 1, 0, 1, 1, 0, 1};
      phase_tol  = '{0, 0, 7, 7, 3, 1, 5, 4};
      req_chan.valid = 1'b0;
      req_chan.word  = '0;
      rsp_chan.ready = 1'b0;
      csr_chan.valid = 1'b0;
      csr_chan.index = CSR_SEARCH_MODE;
      csr_chan.data  = '0;
      reset = 1'b1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Edge words, first with the reset settings, then in tolerance mode.
      foreach (directed_words[i])
         pending_words.push_back(directed_words[i]);
      wait_idle();
      write_reg(CSR_UNUSED, 8'hFF);
      configure(1'b1, 3'd2);
      foreach (directed_words[i])
         pending_words.push_back(directed_words[i]);
      wait_idle();

      for (int p = 0; p < 8; p++) begin
         configure(phase_mode[p][0], TOL_W'(phase_tol[p]));
         if (p == 3)
            holding <= 1'b1;
         steady <= (p == 5);
         for (int i = 0; i < PHASE_WORDS; i++) begin
            a = WORD_W'($urandom);
            b = WORD_W'($urandom);
            c = WORD_W'($urandom);
            // Mix sparse, dense and lopsided words to spread the popcounts.
            case ($urandom_range(0, 4))
               0: w = a & b & c;
               1: w = a | b | c;
               2: w = {a[WORD_W-1:WORD_W/2] & b[WORD_W-1:WORD_W/2],
                       a[WORD_W/2-1:0] | b[WORD_W/2-1:0]};
               3: w = {a[WORD_W-1:WORD_W/2] | b[WORD_W-1:WORD_W/2],
                       a[WORD_W/2-1:0] & b[WORD_W/2-1:0]};
               default: w = a;
            endcase
            pending_words.push_back(w);
         end
         wait_idle();
      end

      repeat (SETTLE_WAIT) @(posedge clock);
      if (mismatch_count == 0)
         $display("tb_top OK");
      else
         $display("tb_top NOT OK");
      $finish;
   end

endmodule
